// File: rtl/rpm_pkg.sv
// Package for the polynomial resultant unit.
// Holds the sequencer state type, the result type and the modular helper functions.
// Depends on nothing.
package rpm_pkg;

  localparam int CW = 32;
  localparam int DW = 2 * CW;

  typedef struct packed {
    logic [CW-1:0] resultant;
    logic          too_long;
  } res_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CHK, S_RED_RD, S_RED_WT, S_RED_DV, S_TRIM, S_TRIM_WT, S_SETUP,
    S_LB1_WT, S_LB1_DN, S_LOOP, S_LC_WT, S_IV, S_IV_DV, S_IV_UPD,
    S_MM, S_MM_ST, S_MM_WT, S_PW, S_PW_M1, S_PW_SQ, S_PW_M2,
    S_DL_I, S_DL_Q, S_DL_QD, S_DL_J, S_DL_V, S_DL_RK, S_DL_W, S_DL_NX,
    S_TR2, S_TR2_WT, S_UPD, S_UPD2, S_UPD3, S_FIN, S_OUT
  } state_t;

  function automatic logic [CW-1:0] msub(logic [CW-1:0] a, logic [CW-1:0] b,
                                         logic [CW-1:0] p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic logic [CW-1:0] mneg(logic [CW-1:0] a, logic [CW-1:0] p);
    return (a == '0) ? '0 : p - a;
  endfunction

endpackage

// File: rtl/poly_resultant_mod_prime_unit.sv
// Top level of the polynomial resultant unit over Z/pZ.
// Depends on rpm_pkg, rpm_front, rpm_fifo, rpm_ram and rpm_back.
//
// Coefficients arrive as transactions on the input queue (push/full), lowest
// degree first, tagged with the polynomial they extend. While full is low, the
// loader takes one transaction per cycle. A transaction with end_of_set closes
// the set: a command goes to the sequencer and full stays high until that set's
// result has been written to the two-entry result queue (empty/pop).
// The sequencer uses one shared divider for all coefficient reductions,
// modular multiplies and inverse divisions. It reduces each coefficient, then
// per remainder step runs an extended-Euclid inverse, (l0-l1+1)*l1 multiplies
// and, unless the remainder is zero with l1 above 1, a power by square and
// multiply. Ovf or a modulus below 2 goes straight to the output state. The
// modulus is written through modulus_wr/modulus, resets to 2, and must only
// change while no set is in flight. Reset empties both queues and clears the
// partial lengths. A stalled result queue holds the sequencer in its final
// state; the loader is held only by its own pending set.
module poly_resultant_mod_prime_unit import rpm_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [CW-1:0] coeff,
  input  logic          which_poly,
  input  logic          end_of_set,
  input  logic          carries_coeff,
  input  logic          modulus_wr,
  input  logic [CW-1:0] modulus,
  output logic          empty,
  input  logic          pop,
  output logic [CW-1:0] resultant,
  output logic          too_long
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(2 * MAX_LEN);
  localparam int QW = 2 * LW + 1;

  logic [CW-1:0] mod_q;
  logic          f_we, b_we;
  logic [AW-1:0] f_waddr, b_waddr, raddr;
  logic [CW-1:0] f_wdata, b_wdata, rdata;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [QW-1:0] cmd_in, cmd_out;
  logic          out_push, out_full, set_done;
  res_t          res_in, res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_q <= CW'(2);
    end else if (modulus_wr) begin
      mod_q <= modulus;
    end
  end

  rpm_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .coeff         (coeff),
    .which_poly    (which_poly),
    .end_of_set    (end_of_set),
    .carries_coeff (carries_coeff),
    .mem_we        (f_we),
    .mem_waddr     (f_waddr),
    .mem_wdata     (f_wdata),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .cmd_full      (cmd_full),
    .set_done      (set_done)
  );

  rpm_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  rpm_ram #(.WIDTH(CW), .DEPTH(2 * MAX_LEN)) u_ram (
    .clk   (clk),
    .we    (f_we | b_we),
    .waddr (f_we ? f_waddr : b_waddr),
    .wdata (f_we ? f_wdata : b_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpm_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .modulus   (mod_q),
    .cmd_valid (~cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .mem_we    (b_we),
    .mem_waddr (b_waddr),
    .mem_wdata (b_wdata),
    .mem_raddr (raddr),
    .mem_rdata (rdata),
    .out_push  (out_push),
    .out_data  (res_in),
    .out_full  (out_full),
    .set_done  (set_done)
  );

  rpm_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign resultant = res_out.resultant;
  assign too_long  = res_out.too_long;

endmodule

// File: rtl/rpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rpm_fifo.sv
// Small register queue used for commands and for results.
// Depends on nothing.
module rpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// File: rtl/rpm_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on rpm_pkg.
module rpm_div import rpm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] quo,
  output logic [CW-1:0] rem
);

  localparam int NW = $clog2(DW);

  logic          bsy;
  logic [NW-1:0] cnt;
  logic [CW-1:0] rr;
  logic [DW-1:0] dq;
  logic [CW-1:0] dv;
  logic [CW:0]   r2;
  logic          ge;

  assign r2  = {rr, dq[DW-1]};
  assign ge  = (r2 >= {1'b0, dv});
  assign quo = dq[CW-1:0];
  assign rem = rr;

  always_ff @(posedge clk) begin
    if (rst) begin
      bsy  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        bsy <= 1'b1;
        cnt <= '0;
        rr  <= '0;
        dq  <= dividend;
        dv  <= divisor;
      end else if (bsy) begin
        rr  <= ge ? CW'(r2 - {1'b0, dv}) : r2[CW-1:0];
        dq  <= {dq[DW-2:0], ge};
        cnt <= cnt + NW'(1);
        if (cnt == NW'(DW - 1)) begin
          bsy  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/rpm_front.sv
// Loader: accepts coefficient transactions, writes the coefficients that fit
// to the coefficient RAM and queues one command per set. Depends on rpm_pkg.
module rpm_front import rpm_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [CW-1:0]                      coeff,
  input  logic                               which_poly,
  input  logic                               end_of_set,
  input  logic                               carries_coeff,
  output logic                               mem_we,
  output logic [$clog2(2*MAX_LEN)-1:0]       mem_waddr,
  output logic [CW-1:0]                      mem_wdata,
  output logic                               cmd_push,
  output logic [2*$clog2(MAX_LEN+1):0]       cmd_data,
  input  logic                               cmd_full,
  input  logic                               set_done
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(2 * MAX_LEN);

  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic          ovf;
  logic          busy;
  logic          accept;
  logic [LW-1:0] cur;
  logic          room;
  logic [LW-1:0] la_next;
  logic [LW-1:0] lb_next;
  logic          ovf_next;

  assign full   = busy | cmd_full;
  assign accept = push & ~full;
  assign cur    = which_poly ? lb : la;
  assign room   = (cur < LW'(MAX_LEN));

  always_comb begin
    la_next  = la;
    lb_next  = lb;
    ovf_next = ovf;
    if (carries_coeff) begin
      if (!room) begin
        ovf_next = 1'b1;
      end else if (which_poly) begin
        lb_next = lb + LW'(1);
      end else begin
        la_next = la + LW'(1);
      end
    end
  end

  assign mem_we    = accept & carries_coeff & room;
  assign mem_waddr = (which_poly ? AW'(MAX_LEN) : AW'(0)) + AW'(cur);
  assign mem_wdata = coeff;
  assign cmd_push  = accept & end_of_set;
  assign cmd_data  = {ovf_next, la_next, lb_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      la   <= '0;
      lb   <= '0;
      ovf  <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (set_done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        if (end_of_set) begin
          la   <= '0;
          lb   <= '0;
          ovf  <= 1'b0;
          busy <= 1'b1;
        end else begin
          la  <= la_next;
          lb  <= lb_next;
          ovf <= ovf_next;
        end
      end
    end
  end

endmodule

// File: rtl/rpm_back.sv
// Sequencer that reduces, trims and runs the Euclidean remainder sequence on the
// loaded polynomials. Depends on rpm_pkg and rpm_div.
module rpm_back import rpm_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CW-1:0]                modulus,
  input  logic                         cmd_valid,
  input  logic [2*$clog2(MAX_LEN+1):0] cmd_data,
  output logic                         cmd_pop,
  output logic                         mem_we,
  output logic [$clog2(2*MAX_LEN)-1:0] mem_waddr,
  output logic [CW-1:0]                mem_wdata,
  output logic [$clog2(2*MAX_LEN)-1:0] mem_raddr,
  input  logic [CW-1:0]                mem_rdata,
  output logic                         out_push,
  output res_t                         out_data,
  input  logic                         out_full,
  output logic                         set_done
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(2 * MAX_LEN);

  state_t state, state_next;
  state_t mm_ret, pw_ret;

  logic [LW-1:0] la, lb, l0, l1, l2, i, j, k, wk, pw_e, cur_len;
  logic          ovf, rg, ui, vi, neg, swap;
  logic [CW-1:0] lc, inv, q, rp, ma, mb, mr, pw_b, pw_r;
  logic [CW-1:0] r0, r1, r2, t0, t1, res_val;
  logic [DW-1:0] pr;
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend;
  logic [CW-1:0] div_divisor, div_quo, div_rem;

  function automatic logic [AW-1:0] addr_of(logic r, logic [LW-1:0] idx);
    return (r ? AW'(MAX_LEN) : AW'(0)) + AW'(idx);
  endfunction

  rpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign cur_len  = rg ? lb : la;
  assign swap     = (la < lb);
  assign wk       = i - l1 + LW'(1) + j;
  assign out_data = '{resultant: res_val, too_long: ovf};
  assign set_done = out_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = addr_of(ui, wk);
    mem_wdata    = msub(mem_rdata, mr, modulus);
    mem_raddr    = addr_of(ui, i);
    out_push     = 1'b0;
    div_start    = 1'b0;
    div_dividend = pr;
    div_divisor  = modulus;
    case (state)
      S_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = (ovf || modulus < CW'(2)) ? S_OUT : S_RED_RD;
      end
      S_RED_RD: begin
        mem_raddr = addr_of(rg, k);
        if (k == cur_len) begin
          state_next = rg ? S_TRIM : S_RED_RD;
        end else begin
          state_next = S_RED_WT;
        end
      end
      S_RED_WT: begin
        div_start    = 1'b1;
        div_dividend = {{CW{1'b0}}, mem_rdata};
        state_next   = S_RED_DV;
      end
      S_RED_DV: begin
        if (div_done) begin
          mem_we     = 1'b1;
          mem_waddr  = addr_of(rg, k);
          mem_wdata  = div_rem;
          state_next = S_RED_RD;
        end
      end
      S_TRIM: begin
        mem_raddr = addr_of(rg, cur_len - LW'(1));
        if (cur_len != '0) begin
          state_next = S_TRIM_WT;
        end else begin
          state_next = rg ? S_SETUP : S_TRIM;
        end
      end
      S_TRIM_WT: begin
        if (mem_rdata == '0) begin
          state_next = S_TRIM;
        end else begin
          state_next = rg ? S_SETUP : S_TRIM;
        end
      end
      S_SETUP: begin
        mem_raddr = addr_of(~swap, '0);
        if (la == '0 || lb == '0) begin
          state_next = S_OUT;
        end else if ((swap ? la : lb) == LW'(1)) begin
          state_next = S_LB1_WT;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LB1_WT: state_next = S_PW;
      S_LB1_DN: state_next = S_FIN;
      S_LOOP: begin
        mem_raddr  = addr_of(vi, l2 - LW'(1));
        state_next = S_LC_WT;
      end
      S_LC_WT: state_next = S_IV;
      S_IV: begin
        div_dividend = {{CW{1'b0}}, r0};
        div_divisor  = r1;
        if (r1 == '0) begin
          state_next = S_DL_I;
        end else begin
          div_start  = 1'b1;
          state_next = S_IV_DV;
        end
      end
      S_IV_DV: begin
        if (div_done) begin
          state_next = S_MM;
        end
      end
      S_IV_UPD: state_next = S_IV;
      S_MM: state_next = S_MM_ST;
      S_MM_ST: begin
        div_start  = 1'b1;
        state_next = S_MM_WT;
      end
      S_MM_WT: begin
        if (div_done) begin
          state_next = mm_ret;
        end
      end
      S_PW: begin
        if (pw_e == '0) begin
          state_next = pw_ret;
        end else if (pw_e[0]) begin
          state_next = S_MM;
        end else begin
          state_next = S_PW_SQ;
        end
      end
      S_PW_M1: state_next = S_PW_SQ;
      S_PW_SQ: state_next = S_MM;
      S_PW_M2: state_next = S_PW;
      S_DL_I: begin
        mem_raddr  = addr_of(ui, i);
        state_next = S_DL_Q;
      end
      S_DL_Q: state_next = S_MM;
      S_DL_QD: state_next = S_DL_J;
      S_DL_J: begin
        mem_raddr = addr_of(vi, j);
        if (j == l1 - LW'(1)) begin
          state_next = S_DL_NX;
        end else begin
          state_next = S_DL_V;
        end
      end
      S_DL_V: state_next = S_MM;
      S_DL_RK: begin
        mem_raddr  = addr_of(ui, wk);
        state_next = S_DL_W;
      end
      S_DL_W: begin
        mem_we     = 1'b1;
        state_next = S_DL_J;
      end
      S_DL_NX: begin
        state_next = (i == l1 - LW'(1)) ? S_TR2 : S_DL_I;
      end
      S_TR2: begin
        mem_raddr = addr_of(ui, l2 - LW'(1));
        state_next = (l2 != '0) ? S_TR2_WT : S_UPD;
      end
      S_TR2_WT: begin
        state_next = (mem_rdata == '0) ? S_TR2 : S_UPD;
      end
      S_UPD: begin
        state_next = (l2 != '0 || l1 == LW'(1)) ? S_PW : S_FIN;
      end
      S_UPD2: state_next = S_MM;
      S_UPD3: state_next = (l2 != '0) ? S_LOOP : S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        {ovf, la, lb} <= cmd_data;
        rg      <= 1'b0;
        k       <= '0;
        res_val <= '0;
      end
      S_RED_RD: begin
        if (k == cur_len) begin
          rg <= ~rg;
          k  <= '0;
        end
      end
      S_RED_DV: begin
        if (div_done) begin
          k <= k + LW'(1);
        end
      end
      S_TRIM: begin
        if (cur_len == '0) begin
          rg <= 1'b1;
        end
      end
      S_TRIM_WT: begin
        if (mem_rdata == '0) begin
          if (rg) begin
            lb <= lb - LW'(1);
          end else begin
            la <= la - LW'(1);
          end
        end else begin
          rg <= 1'b1;
        end
      end
      S_SETUP: begin
        l1  <= swap ? lb : la;
        l2  <= swap ? la : lb;
        ui  <= swap;
        vi  <= ~swap;
        neg <= swap & ~la[0] & ~lb[0];
        rp  <= CW'(1);
      end
      S_LB1_WT: begin
        pw_b   <= mem_rdata;
        pw_e   <= l1 - LW'(1);
        pw_r   <= CW'(1);
        pw_ret <= S_LB1_DN;
      end
      S_LB1_DN: rp <= pw_r;
      S_LOOP: begin
        l0 <= l1;
        l1 <= l2;
      end
      S_LC_WT: begin
        lc <= mem_rdata;
        r0 <= modulus;
        r1 <= mem_rdata;
        t0 <= '0;
        t1 <= CW'(1);
      end
      S_IV: begin
        if (r1 == '0) begin
          inv <= (r0 == CW'(1)) ? t0 : '0;
          i   <= l0 - LW'(1);
        end
      end
      S_IV_DV: begin
        r2     <= div_rem;
        ma     <= (div_quo >= modulus) ? div_quo - modulus : div_quo;
        mb     <= t1;
        mm_ret <= S_IV_UPD;
      end
      S_IV_UPD: begin
        r0 <= r1;
        r1 <= r2;
        t0 <= t1;
        t1 <= msub(t0, mr, modulus);
      end
      S_MM: pr <= ma * mb;
      S_MM_WT: begin
        if (div_done) begin
          mr <= div_rem;
        end
      end
      S_PW: begin
        ma     <= pw_r;
        mb     <= pw_b;
        mm_ret <= S_PW_M1;
      end
      S_PW_M1: pw_r <= mr;
      S_PW_SQ: begin
        ma     <= pw_b;
        mb     <= pw_b;
        mm_ret <= S_PW_M2;
      end
      S_PW_M2: begin
        pw_b <= mr;
        pw_e <= pw_e >> 1;
      end
      S_DL_Q: begin
        ma     <= mem_rdata;
        mb     <= inv;
        mm_ret <= S_DL_QD;
      end
      S_DL_QD: begin
        q <= mr;
        j <= '0;
      end
      S_DL_V: begin
        ma     <= q;
        mb     <= mem_rdata;
        mm_ret <= S_DL_RK;
      end
      S_DL_W: j <= j + LW'(1);
      S_DL_NX: begin
        if (i == l1 - LW'(1)) begin
          l2 <= l1 - LW'(1);
        end else begin
          i <= i - LW'(1);
        end
      end
      S_TR2_WT: begin
        if (mem_rdata == '0) begin
          l2 <= l2 - LW'(1);
        end
      end
      S_UPD: begin
        ui     <= vi;
        vi     <= ui;
        pw_b   <= lc;
        pw_e   <= (l2 != '0) ? l0 - l2 : l0 - LW'(1);
        pw_r   <= CW'(1);
        pw_ret <= S_UPD2;
        if (l2 == '0 && l1 != LW'(1)) begin
          rp <= '0;
        end
      end
      S_UPD2: begin
        ma     <= rp;
        mb     <= pw_r;
        mm_ret <= S_UPD3;
      end
      S_UPD3: begin
        rp <= (l2 != '0 && !l0[0] && !l1[0]) ? mneg(mr, modulus) : mr;
      end
      S_FIN: res_val <= neg ? mneg(rp, modulus) : rp;
      default: begin
      end
    endcase
  end

endmodule

// File: tb/sv/tb_poly_resultant_mod_prime_unit.sv
// Self-checking testbench for poly_resultant_mod_prime_unit.
// Sends coefficient sets through the input queue and checks each resultant
// against a behavioral predictor; depends on rpm_pkg and the unit's RTL.
module tb_poly_resultant_mod_prime_unit import rpm_pkg::*; ();

  localparam int MAXL = 64;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [CW-1:0] resultant;
    logic          too_long;
  } answer_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  logic [CW-1:0] coeff = '0;
  logic          which_poly = 1'b0;
  logic          end_of_set = 1'b0;
  logic          carries_coeff = 1'b0;
  logic          modulus_wr = 1'b0;
  logic [CW-1:0] modulus = 32'd2;
  logic          empty;
  logic          pop = 1'b0;
  logic [CW-1:0] resultant;
  logic          too_long;

  answer_t         answer_q[$];
  longint unsigned poly_mem[3][MAXL];
  int              len_a, len_b;
  bit              ovf_pending;
  longint unsigned cur_p;
  int              errors;
  bit              idle_en;
  int              pop_hold;
  longint          cycles;
  int              sent;

  poly_resultant_mod_prime_unit #(.MAX_LEN(MAXL)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .coeff(coeff),
    .which_poly(which_poly), .end_of_set(end_of_set), .carries_coeff(carries_coeff),
    .modulus_wr(modulus_wr), .modulus(modulus), .empty(empty), .pop(pop),
    .resultant(resultant), .too_long(too_long)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
    return (a * b) % p;
  endfunction

  function automatic longint unsigned mod_sub(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic longint unsigned mod_neg(longint unsigned a, longint unsigned p);
    return (a == 0) ? 0 : p - a;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, int e, longint unsigned p);
    longint unsigned r;
    r = 1 % p;
    while (e != 0) begin
      if (e & 1) r = mod_mul(r, b, p);
      b = mod_mul(b, b, p);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned mod_inv(longint unsigned v, longint unsigned p);
    longint unsigned r0, r1, t0, t1, q, r2, t2;
    r0 = p; r1 = v; t0 = 0; t1 = 1 % p;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t2 = mod_sub(t0, mod_mul(q % p, t1, p), p);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    return (r0 == 1) ? t0 : 0;
  endfunction

  function automatic longint unsigned remainder_chain(int ia, int la, int ib, int lb,
                                                      longint unsigned p);
    int ui, vi, ri, l0, l1, l2, t;
    longint unsigned lc, inv, q, acc;
    ui = ia; vi = ib; ri = 3 - ia - ib;
    l1 = la; l2 = lb;
    if (lb == 1) return (la == 1) ? 1 % p : mod_pow(poly_mem[ib][0], la - 1, p);
    acc = 1;
    do begin
      l0 = l1;
      l1 = l2;
      lc = poly_mem[vi][l1-1];
      inv = mod_inv(lc, p);
      for (int i = 0; i < l0; i++) poly_mem[ri][i] = poly_mem[ui][i];
      for (int i = l0 - 1; i >= l1 - 1; i--) begin
        q = mod_mul(poly_mem[ri][i], inv, p);
        for (int j = 0; j + 1 < l1; j++)
          poly_mem[ri][i-(l1-1)+j] = mod_sub(poly_mem[ri][i-(l1-1)+j],
                                             mod_mul(q, poly_mem[vi][j], p), p);
        poly_mem[ri][i] = 0;
      end
      l2 = l1 - 1;
      while (l2 > 0 && poly_mem[ri][l2-1] == 0) l2--;
      t = ui; ui = vi; vi = ri; ri = t;
      if (l2 >= 1) begin
        acc = mod_mul(acc, mod_pow(lc, l0 - l2, p), p);
        if (((l0 | l1) & 1) == 0) acc = mod_neg(acc, p);
      end else if (l1 == 1) begin
        acc = mod_mul(acc, mod_pow(lc, l0 - 1, p), p);
      end else begin
        acc = 0;
      end
    end while (l2 > 0);
    return acc;
  endfunction

  function automatic longint unsigned predict_resultant();
    int la, lb;
    longint unsigned r;
    la = len_a; lb = len_b;
    if (cur_p < 2) return 0;
    for (int k = 0; k < la; k++) poly_mem[0][k] = poly_mem[0][k] % cur_p;
    for (int k = 0; k < lb; k++) poly_mem[1][k] = poly_mem[1][k] % cur_p;
    while (la > 0 && poly_mem[0][la-1] == 0) la--;
    while (lb > 0 && poly_mem[1][lb-1] == 0) lb--;
    if (la == 0 || lb == 0) return 0;
    if (la >= lb) return remainder_chain(0, la, 1, lb, cur_p);
    r = remainder_chain(1, lb, 0, la, cur_p);
    if (((la | lb) & 1) == 0) r = mod_neg(r, cur_p);
    return r;
  endfunction

  task automatic absorb_item(logic [CW-1:0] c, logic w, logic e, logic cc);
    answer_t a;
    if (cc) begin
      if (w) begin
        if (len_b >= MAXL) ovf_pending = 1'b1;
        else begin poly_mem[1][len_b] = 64'(c); len_b++; end
      end else begin
        if (len_a >= MAXL) ovf_pending = 1'b1;
        else begin poly_mem[0][len_a] = 64'(c); len_a++; end
      end
    end
    if (e) begin
      if (ovf_pending) begin
        a.resultant = '0;
        a.too_long = 1'b1;
      end else begin
        a.resultant = CW'(predict_resultant());
        a.too_long = 1'b0;
      end
      answer_q.push_back(a);
      len_a = 0; len_b = 0; ovf_pending = 1'b0;
    end
  endtask

  task automatic send_item(logic [CW-1:0] c, logic w, logic e, logic cc);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push <= 1'b1;
    coeff <= c;
    which_poly <= w;
    end_of_set <= e;
    carries_coeff <= cc;
    do @(posedge clk); while (full);
    absorb_item(c, w, e, cc);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_modulus(logic [CW-1:0] v);
    push <= 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);
    modulus_wr <= 1'b1;
    modulus <= v;
    @(negedge clk);
    modulus_wr <= 1'b0;
    cur_p = 64'(v);
  endtask

  function automatic logic [CW-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return CW'(cur_p - 1);
      default: return CW'($urandom() % cur_p);
    endcase
  endfunction

  task automatic send_set(int la, int lb);
    int na, nb;
    logic w;
    bit bare_end;
    na = 0; nb = 0;
    bare_end = $urandom_range(0, 3) == 0 || (la + lb == 0);
    while (na + nb < la + lb) begin
      if (na == la) w = 1'b1;
      else if (nb == lb) w = 1'b0;
      else w = 1'($urandom_range(0, 1));
      if (w) nb++; else na++;
      send_item(pick_coeff(), w, !bare_end && (na + nb == la + lb), 1'b1);
    end
    if (bare_end) send_item($urandom(), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
  endtask

  task automatic test_directed();
    set_modulus(32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFA, 1'b1, 1'b0, 1'b1);
    send_item(32'h0000_0001, 1'b1, 1'b1, 1'b1);
    send_item(32'h0, 1'b0, 1'b1, 1'b0);
    send_item(32'h5, 1'b0, 1'b0, 1'b1);
    send_item(32'h0, 1'b0, 1'b1, 1'b1);
    send_item(32'h3, 1'b0, 1'b0, 1'b1);
    send_item(32'h7, 1'b1, 1'b0, 1'b1);
    send_item(32'h2, 1'b1, 1'b0, 1'b1);
    send_item(32'h9, 1'b1, 1'b1, 1'b1);
    send_item(32'h3, 1'b0, 1'b0, 1'b1);
    send_item(32'h4, 1'b0, 1'b0, 1'b1);
    send_item(32'h1, 1'b1, 1'b0, 1'b1);
    send_item(32'h8, 1'b1, 1'b0, 1'b1);
    send_item(32'h2, 1'b1, 1'b0, 1'b1);
    send_item(32'h6, 1'b1, 1'b1, 1'b1);
    send_item(32'h4, 1'b0, 1'b0, 1'b1);
    send_item(32'h0, 1'b0, 1'b0, 1'b1);
    send_item(32'h0, 1'b0, 1'b0, 1'b1);
    send_item(32'hB, 1'b1, 1'b1, 1'b1);
    send_item(32'h8000_0000, 1'b0, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFA, 1'b0, 1'b0, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFA, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    for (int k = 0; k < MAXL + 1; k++) send_item(pick_coeff(), 1'b0, 1'b0, 1'b1);
    send_item(pick_coeff(), 1'b1, 1'b1, 1'b1);
    for (int k = 0; k < MAXL; k++) send_item(pick_coeff(), 1'b1, 1'b0, 1'b1);
    send_item(pick_coeff(), 1'b0, 1'b0, 1'b1);
    send_item(pick_coeff(), 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_random(int quota);
    int start;
    int la, lb;
    start = sent;
    while (sent - start < quota) begin
      case ($urandom_range(0, 39))
        0: send_set(MAXL, $urandom_range(1, 2));
        1: send_set($urandom_range(MAXL - 1, MAXL + 1), $urandom_range(0, 3));
        2, 3, 4: send_item($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
        default: begin
          la = $urandom_range(0, 6);
          lb = $urandom_range(0, 6);
          send_set(la, lb);
        end
      endcase
    end
  endtask

  task automatic test_pause();
    push <= 1'b0;
    wait_drained();
    @(negedge clk);
    send_set(5, 4);
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: resultant=%h too_long=%b", resultant, too_long);
      end else begin
        answer_t a;
        a = answer_q.pop_front();
        if (resultant !== a.resultant || too_long !== a.too_long) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected resultant=%h too_long=%b, got resultant=%h too_long=%b",
                     a.resultant, a.too_long, resultant, too_long);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0; len_a = 0; len_b = 0; ovf_pending = 1'b0; cur_p = 2;
    idle_en = 1'b1; pop_hold = 0; cycles = 0; sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_random(40);
    test_directed();
    test_overflow();
    set_modulus(32'd3);
    test_random(150);
    set_modulus(32'd65521);
    test_random(150);
    test_pause();
    set_modulus(32'hFFFF_FFFF);
    test_random(150);
    set_modulus(32'd7);
    test_random(150);
    set_modulus(32'd2147483647);
    test_random(150);
    idle_en = 1'b0;
    set_modulus(32'hFFFF_FFFB);
    test_random(200);
    push <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
